// ===== design/deoc_pkg.sv =====
// Package for the dual encoder counter / odometry core.
// Holds register reset values, request and register codes, the back-end
// state type and the configuration struct. No dependencies.
`default_nettype none

package deoc_pkg;

  // Default sizing
  localparam int WHEELS_DEF     = 2;
  localparam int COUNT_BITS_DEF = 16;

  // Register reset values
  localparam logic [14:0] COUNT_LIMIT_RST   = 15'd30000;
  localparam logic [9:0]  FILTER_LEN_RST    = 10'd100;
  localparam logic [31:0] RAD_PER_COUNT_RST = 32'd1001337;
  localparam logic [15:0] PERIOD_MS_RST     = 16'd0;

  // Glitch filter tick counter ceiling
  localparam logic [9:0] TICK_MAX = 10'd1023;

  // Quotient bits produced by the speed divider (one per cycle)
  localparam int DIV_STEPS = 48;

  // Request kinds carried on tuser
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_SNAP   = 1'b1;

  // Register indexes
  typedef enum logic [1:0] {
    CFG_COUNT_LIMIT   = 2'd0,
    CFG_FILTER_LEN    = 2'd1,
    CFG_RAD_PER_COUNT = 2'd2,
    CFG_PERIOD_MS     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [14:0] count_limit;
    logic [9:0]  filter_len;
    logic [31:0] rad_per_count;
    logic [15:0] period_ms;
  } cfg_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_TOTAL,
    BK_MUL_SPD,
    BK_SCALE,
    BK_DIV,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_ANGLE,
    BK_OUT
  } bk_state_e;

endpackage

`default_nettype wire

// ===== design/deoc_front.sv =====
// Front end: per-lane pin glitch filters and pulse counters.
// Captures and clears the counters on a snapshot. Depends on deoc_pkg.
`default_nettype none

module deoc_front import deoc_pkg::*; #(
  parameter int WHEELS     = WHEELS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  cfg_t                        cfg_i,
  input  wire                         sample_i,
  input  wire                         snap_i,
  input  wire  [3:0]                  pins_i,       // left a, left b, right a, right b
  output logic [2*COUNT_BITS-1:0]     snap_delta_o  // lane 0 low, lane 1 high
);

  localparam int LW = ((COUNT_BITS > 15) ? COUNT_BITS : 15) + 2;
  localparam logic signed [LW-1:0] CAP = LW'(1) <<< (COUNT_BITS - 1);

  logic signed [LW-1:0] lim;

  // Effective limit: smaller of the register and the counter range
  always_comb begin
    lim = LW'(cfg_i.count_limit);
    if (lim > CAP) lim = CAP;
  end

  logic signed [COUNT_BITS-1:0] cnt_q [WHEELS];

  for (genvar l = 0; l < WHEELS; l++) begin : g_lane
    logic [1:0] raw;
    logic [1:0] filt_q, filt_d, pend_q, pend_d;
    logic [9:0] tick_q [2];
    logic [9:0] tick_d [2];
    logic signed [COUNT_BITS-1:0] cnt_d;

    if (l < 2) begin : g_pins
      assign raw = pins_i[2*l+1:2*l];
    end else begin : g_nopins
      assign raw = 2'b00;
    end

    // Glitch filter, A then B
    always_comb begin
      logic [9:0] t;
      filt_d = filt_q;
      pend_d = pend_q;
      for (int p = 0; p < 2; p++) begin
        t = tick_q[p];
        if (raw[p] == filt_q[p]) begin
          t = '0;
        end else begin
          if (pend_q[p] != raw[p]) t = '0;
          if (t != TICK_MAX) t = t + 10'd1;
          if (t >= cfg_i.filter_len) begin
            filt_d[p] = raw[p];
            t = '0;
          end
        end
        pend_d[p] = raw[p];
        tick_d[p] = t;
      end
    end

    // Count filtered A edges, direction flipped by filtered B
    always_comb begin
      logic signed [LW-1:0] sum;
      sum   = LW'(cnt_q[l]);
      cnt_d = cnt_q[l];
      if (snap_i) begin
        cnt_d = '0;
      end else if (sample_i && (filt_d[0] != filt_q[0])) begin
        if (filt_d[0] ^ filt_d[1]) sum = sum + LW'(1);
        else sum = sum - LW'(1);
        if ((sum >= lim) || (sum <= -lim)) cnt_d = '0;
        else cnt_d = COUNT_BITS'(sum);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        filt_q    <= '0;
        pend_q    <= '0;
        tick_q[0] <= '0;
        tick_q[1] <= '0;
        cnt_q[l]  <= '0;
      end else begin
        if (sample_i) begin
          filt_q    <= filt_d;
          pend_q    <= pend_d;
          tick_q[0] <= tick_d[0];
          tick_q[1] <= tick_d[1];
        end
        cnt_q[l] <= cnt_d;
      end
    end
  end

  // Deltas for the two reported lanes
  for (genvar o = 0; o < 2; o++) begin : g_out
    if (o < WHEELS) begin : g_live
      assign snap_delta_o[o*COUNT_BITS +: COUNT_BITS] = cnt_q[o];
    end else begin : g_dead
      assign snap_delta_o[o*COUNT_BITS +: COUNT_BITS] = '0;
    end
  end

endmodule

`default_nettype wire

// ===== design/deoc_fifo.sv =====
// Two-entry queue between front and back ends.
// Standalone, no package dependency.
`default_nettype none

module deoc_fifo #(
  parameter int W = 32
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          push_i,
  input  wire  [W-1:0] wdata_i,
  input  wire          pop_i,
  output logic         full_o,
  output logic         valid_o,
  output logic [W-1:0] rdata_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

`default_nettype wire

// ===== design/deoc_back.sv =====
// Back end: running totals, speed (shared multiplier plus serial divider)
// and angle per snapshot, and the output register. Depends on deoc_pkg.
`default_nettype none

module deoc_back import deoc_pkg::*; #(
  parameter int WHEELS     = WHEELS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  cfg_t                     cfg_i,
  input  wire                      q_valid_i,
  input  wire  [2*COUNT_BITS-1:0]  q_data_i,
  output logic                     q_pop_o,
  output logic                     m_valid_o,
  input  wire                      m_ready_i,
  output logic [223:0]             m_data_o
);

  localparam int DCW = $clog2(DIV_STEPS);

  bk_state_e state_q, state_d;
  logic      lane_q;

  logic signed [COUNT_BITS-1:0] dlt_q [2];
  logic signed [63:0]           tot_q [2];
  logic [31:0]                  spd_q [2];
  logic [63:0]                  ang_q [2];
  logic [63:0]                  mul_q, lo_q, mul_d;
  logic [16:0]                  rem_q;
  logic [DIV_STEPS-1:0]         num_q;
  logic [DCW-1:0]               dcnt_q;
  logic                         out_free;

  logic signed [COUNT_BITS-1:0] cur_d;
  logic signed [63:0]           cur_t;
  logic [31:0]                  mag_d;
  logic [63:0]                  mag_t;
  logic [31:0]                  mul_a;

  assign out_free = !m_valid_o || m_ready_i;
  assign cur_d    = dlt_q[lane_q];
  assign cur_t    = tot_q[lane_q];
  assign mag_d    = cur_d[COUNT_BITS-1] ? (32'd0 - 32'(cur_d)) : 32'(cur_d);
  assign mag_t    = cur_t[63] ? (64'd0 - cur_t) : cur_t;

  // Shared 32x32 multiplier, result registered
  always_comb begin
    case (state_q)
      BK_MUL_LO: mul_a = mag_t[31:0];
      BK_MUL_HI: mul_a = mag_t[63:32];
      default:   mul_a = mag_d;
    endcase
    mul_d = 64'(mul_a) * 64'(cfg_i.rad_per_count);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:    if (q_valid_i) state_d = BK_TOTAL;
      BK_TOTAL:   state_d = BK_MUL_SPD;
      BK_MUL_SPD: state_d = BK_SCALE;
      BK_SCALE:   state_d = (cfg_i.period_ms == 16'd0) ? BK_MUL_LO : BK_DIV;
      BK_DIV:     if (dcnt_q == DCW'(DIV_STEPS - 1)) state_d = BK_MUL_LO;
      BK_MUL_LO:  state_d = BK_MUL_HI;
      BK_MUL_HI:  state_d = BK_ANGLE;
      BK_ANGLE:   state_d = (!lane_q && (WHEELS > 1)) ? BK_MUL_SPD : BK_OUT;
      BK_OUT:     if (out_free) state_d = BK_IDLE;
      default:    state_d = BK_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop_o = (state_q == BK_IDLE) && q_valid_i;
  end

  // Arithmetic helpers for the current lane
  logic [63:0] scaled;
  logic [16:0] rtry;
  logic [31:0] spd_sat;
  logic [63:0] ang_r, ang_lim, ang_sum;

  always_comb begin
    // x1000 as x1024 - x16 - x8, plus half the divisor for rounding
    scaled = (mul_q << 10) - (mul_q << 4) - (mul_q << 3) + {33'd0, cfg_i.period_ms, 15'd0};
    rtry   = {rem_q[15:0], num_q[DIV_STEPS-1]};
    if (cur_d[COUNT_BITS-1]) begin
      spd_sat = (num_q > DIV_STEPS'(64'h8000_0000)) ? 32'h8000_0000
                                                    : 32'd0 - num_q[31:0];
    end else begin
      spd_sat = (num_q > DIV_STEPS'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : num_q[31:0];
    end
    ang_lim = cur_t[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    ang_sum = (mul_q << 16) + ((lo_q + 64'h8000) >> 16);
    if (mul_q[63:47] != '0) ang_r = ang_lim;
    else if (ang_sum > ang_lim) ang_r = ang_lim;
    else ang_r = ang_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      lane_q    <= 1'b0;
      tot_q[0]  <= '0;
      tot_q[1]  <= '0;
      m_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      // Result valid: set when the output register loads, cleared on handoff
      if ((state_q == BK_OUT) && out_free) m_valid_o <= 1'b1;
      else if (m_ready_i) m_valid_o <= 1'b0;
      case (state_q)
        BK_TOTAL: begin
          // Saturating add of each delta into its total
          for (int i = 0; i < 2; i++) begin
            logic signed [63:0] d64, s;
            d64 = 64'(dlt_q[i]);
            s   = tot_q[i] + d64;
            if (!d64[63] && !tot_q[i][63] && s[63]) tot_q[i] <= 64'h7FFF_FFFF_FFFF_FFFF;
            else if (d64[63] && tot_q[i][63] && !s[63]) tot_q[i] <= 64'h8000_0000_0000_0000;
            else tot_q[i] <= s;
          end
          lane_q <= 1'b0;
        end
        BK_ANGLE: lane_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        dlt_q[0] <= q_data_i[COUNT_BITS-1:0];
        dlt_q[1] <= q_data_i[2*COUNT_BITS-1:COUNT_BITS];
      end
      BK_MUL_SPD: mul_q <= mul_d;
      BK_SCALE: begin
        spd_q[lane_q] <= 32'd0;
        num_q  <= scaled[63:16];
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      BK_DIV: begin
        // Restoring division, one quotient bit per cycle
        if (rtry >= {1'b0, cfg_i.period_ms}) begin
          rem_q <= rtry - {1'b0, cfg_i.period_ms};
          num_q <= {num_q[DIV_STEPS-2:0], 1'b1};
        end else begin
          rem_q <= rtry;
          num_q <= {num_q[DIV_STEPS-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q + DCW'(1);
      end
      BK_MUL_LO: begin
        if (cfg_i.period_ms != 16'd0) spd_q[lane_q] <= spd_sat;
        mul_q <= mul_d;
      end
      BK_MUL_HI: begin
        lo_q  <= mul_q;
        mul_q <= mul_d;
      end
      BK_ANGLE: ang_q[lane_q] <= cur_t[63] ? (64'd0 - ang_r) : ang_r;
      BK_OUT: begin
        if (out_free) begin
          m_data_o[15:0]    <= 16'(dlt_q[0]);
          m_data_o[63:32]   <= spd_q[0];
          m_data_o[159:96]  <= ang_q[0];
          if (WHEELS > 1) begin
            m_data_o[31:16]   <= 16'(dlt_q[1]);
            m_data_o[95:64]   <= spd_q[1];
            m_data_o[223:160] <= ang_q[1];
          end else begin
            m_data_o[31:16]   <= '0;
            m_data_o[95:64]   <= '0;
            m_data_o[223:160] <= '0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/dual_encoder_counter_odometry_core.sv =====
// Top level of the dual encoder counter / odometry core.
// Instantiates deoc_front, deoc_fifo and deoc_back; depends on deoc_pkg.
//
// Sample items (tuser = 0) are taken one per clock and update the pin filters
// and pulse counters in that cycle. A snapshot item (tuser = 1) copies and
// clears the counters into a two-entry queue; the back end then takes each
// snapshot off the queue and, once per lane, runs the shared 32x32
// multiplier and the one-bit-per-cycle speed divider (skipped with a zero
// period) before presenting its result, which waits out any output stall.
// The input stalls only while that queue is full.
`default_nettype none

module dual_encoder_counter_odometry_core import deoc_pkg::*; #(
  parameter int WHEELS     = WHEELS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire  [1:0]   cfg_addr_i,
  input  wire  [31:0]  cfg_wdata_i,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [7:0]   s_axis_tdata,  // left_a, left_b, right_a, right_b, zero pad
  input  wire          s_axis_tuser,  // req_type
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [223:0] m_axis_tdata   // left_delta, right_delta, left_speed,
                                      // right_speed, left_angle, right_angle
);

  cfg_t cfg_q;
  logic accept, q_full, q_valid, q_pop;
  logic [2*COUNT_BITS-1:0] snap_delta, q_data;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.count_limit   <= COUNT_LIMIT_RST;
      cfg_q.filter_len    <= FILTER_LEN_RST;
      cfg_q.rad_per_count <= RAD_PER_COUNT_RST;
      cfg_q.period_ms     <= PERIOD_MS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_COUNT_LIMIT:   cfg_q.count_limit   <= cfg_wdata_i[14:0];
        CFG_FILTER_LEN:    cfg_q.filter_len    <= cfg_wdata_i[9:0];
        CFG_RAD_PER_COUNT: cfg_q.rad_per_count <= cfg_wdata_i;
        CFG_PERIOD_MS:     cfg_q.period_ms     <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  deoc_front #(.WHEELS(WHEELS), .COUNT_BITS(COUNT_BITS)) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .sample_i     (accept && (s_axis_tuser == REQ_SAMPLE)),
    .snap_i       (accept && (s_axis_tuser == REQ_SNAP)),
    .pins_i       (s_axis_tdata[3:0]),
    .snap_delta_o (snap_delta)
  );

  deoc_fifo #(.W(2*COUNT_BITS)) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (accept && (s_axis_tuser == REQ_SNAP)),
    .wdata_i (snap_delta),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .rdata_o (q_data)
  );

  deoc_back #(.WHEELS(WHEELS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== design/deoc_checker.sv =====
// Port-level checks for the odometry core, bound to the top level.
// Depends on deoc_pkg for the default counter width.
`default_nettype none

module deoc_props import deoc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input wire         clk_i,
  input wire         rst_ni,
  input wire         m_axis_tvalid,
  input wire         m_axis_tready,
  input wire [223:0] m_axis_tdata
);

  // A waiting result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // No motion means no speed
  a_zero_spd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[15:0] == 16'd0) |-> (m_axis_tdata[63:32] == 32'd0))
    else $error("left speed nonzero with zero delta");

  // Forward motion never yields a negative speed
  a_spd_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (COUNT_BITS <= 16) && !m_axis_tdata[31]
      |-> !m_axis_tdata[95])
    else $error("right speed sign disagrees with delta");

  // Counter never reaches the most negative code
  a_delta_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (COUNT_BITS <= 16) |-> (m_axis_tdata[15:0] != 16'h8000))
    else $error("left delta out of range");

endmodule

bind dual_encoder_counter_odometry_core deoc_props #(.COUNT_BITS(COUNT_BITS)) u_deoc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== bench/deoc_checker.sv =====
// Checker for the dual encoder counter / odometry core: watches both streams,
// models the pin filters, counters and snapshot math, compares results.
// Depends on deoc_pkg.
`timescale 1ns / 100ps

module deoc_checker import deoc_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire  [1:0]   cfg_addr_i,
  input  wire  [31:0]  cfg_wdata_i,
  input  wire          s_axis_tvalid,
  input  wire          s_axis_tready,
  input  wire  [7:0]   s_axis_tdata,
  input  wire          s_axis_tuser,
  input  wire          m_axis_tvalid,
  input  wire          m_axis_tready,
  input  wire  [223:0] m_axis_tdata,
  output int           fail_cnt_o,
  output int           pending_o,
  output int           snaps_o
);

  cfg_t        cfg;
  logic [1:0]  filt_q [2];
  logic [1:0]  pend_q [2];
  logic [9:0]  ticks_q [4];
  int          pulses_q [2];
  logic signed [63:0] total_q [2];
  logic [223:0] snap_fifo [$];

  assign pending_o = snap_fifo.size();

  task automatic report(input string what, input logic [223:0] got, input logic [223:0] exp);
    $display("MISMATCH %s: got %h exp %h", what, got, exp);
    fail_cnt_o++;
  endtask

  // One glitch filter step for one pin
  task automatic filter_pin(input int lane, input int pin, input logic raw);
    int t;
    t = ticks_q[lane*2+pin];
    if (raw == filt_q[lane][pin]) begin
      ticks_q[lane*2+pin] = 0;
      pend_q[lane][pin] = raw;
      return;
    end
    if (pend_q[lane][pin] != raw) begin
      pend_q[lane][pin] = raw;
      t = 0;
    end
    if (t < 1023) t++;
    if (t >= cfg.filter_len) begin
      filt_q[lane][pin] = raw;
      t = 0;
    end
    ticks_q[lane*2+pin] = t[9:0];
  endtask

  task automatic sample_lane(input int lane, input logic a, input logic b);
    logic old_a;
    int   step;
    int   lim;
    old_a = filt_q[lane][0];
    filter_pin(lane, 0, a);
    filter_pin(lane, 1, b);
    if (filt_q[lane][0] == old_a) return;
    step = filt_q[lane][0] ? 1 : -1;
    if (filt_q[lane][1]) step = -step;
    lim = (cfg.count_limit > 32768) ? 32768 : cfg.count_limit;
    pulses_q[lane] += step;
    if (pulses_q[lane] >= lim || pulses_q[lane] <= -lim) pulses_q[lane] = 0;
  endtask

  function automatic logic [31:0] speed_of(input int d);
    logic [127:0] mag, den, q;
    if (cfg.period_ms == 0) return 32'd0;
    mag = (d < 0) ? -d : d;
    mag = mag * cfg.rad_per_count * 1000;
    den = {96'd0, cfg.period_ms, 16'd0};
    q = (mag + den / 2) / den;
    if (d < 0) begin
      if (q > 128'h80000000) q = 128'h80000000;
      return -q[31:0];
    end
    if (q > 128'h7FFFFFFF) q = 128'h7FFFFFFF;
    return q[31:0];
  endfunction

  function automatic logic [63:0] angle_of(input logic signed [63:0] tot);
    logic [63:0]  mag;
    logic [127:0] prod, r, lim;
    mag = tot[63] ? -tot : tot;
    lim = tot[63] ? (128'd1 << 63) : ((128'd1 << 63) - 1);
    prod = mag * cfg.rad_per_count;
    r = (prod + 128'h8000) >> 16;
    if (r > lim) r = lim;
    return tot[63] ? -r[63:0] : r[63:0];
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] t, input int d);
    logic signed [64:0] s;
    s = $signed({t[63], t}) + d;
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  // Track configuration, accepted items and results
  always @(posedge clk_i or negedge rst_ni) begin
    logic [223:0] res, exp;
    int d [2];
    if (!rst_ni) begin
      cfg <= '{COUNT_LIMIT_RST, FILTER_LEN_RST, RAD_PER_COUNT_RST, PERIOD_MS_RST};
      for (int i = 0; i < 2; i++) begin
        filt_q[i] = '0; pend_q[i] = '0; pulses_q[i] = 0; total_q[i] = '0;
      end
      for (int i = 0; i < 4; i++) ticks_q[i] = '0;
      fail_cnt_o = 0;
      snaps_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_COUNT_LIMIT:   cfg.count_limit   = cfg_wdata_i[14:0];
          CFG_FILTER_LEN:    cfg.filter_len    = cfg_wdata_i[9:0];
          CFG_RAD_PER_COUNT: cfg.rad_per_count = cfg_wdata_i;
          CFG_PERIOD_MS:     cfg.period_ms     = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == REQ_SAMPLE) begin
          sample_lane(0, s_axis_tdata[0], s_axis_tdata[1]);
          sample_lane(1, s_axis_tdata[2], s_axis_tdata[3]);
        end else begin
          for (int i = 0; i < 2; i++) begin
            d[i] = pulses_q[i];
            pulses_q[i] = 0;
            total_q[i] = add_sat(total_q[i], d[i]);
          end
          res = {angle_of(total_q[1]), angle_of(total_q[0]), speed_of(d[1]),
                 speed_of(d[0]), d[1][15:0], d[0][15:0]};
          snap_fifo.push_back(res);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        snaps_o++;
        if (snap_fifo.size() == 0) begin
          report("unexpected result", m_axis_tdata, '0);
        end else begin
          exp = snap_fifo.pop_front();
          if (m_axis_tdata[15:0] !== exp[15:0]) report("left_delta", m_axis_tdata, exp);
          if (m_axis_tdata[31:16] !== exp[31:16]) report("right_delta", m_axis_tdata, exp);
          if (m_axis_tdata[63:32] !== exp[63:32]) report("left_speed", m_axis_tdata, exp);
          if (m_axis_tdata[95:64] !== exp[95:64]) report("right_speed", m_axis_tdata, exp);
          if (m_axis_tdata[159:96] !== exp[159:96]) report("left_angle", m_axis_tdata, exp);
          if (m_axis_tdata[223:160] !== exp[223:160]) report("right_angle", m_axis_tdata, exp);
        end
      end
    end
  end

endmodule

// ===== bench/dual_encoder_counter_odometry_core_tb.sv =====
// Testbench top for the dual encoder counter / odometry core: drives encoder
// waveforms, snapshots and register settings. Depends on deoc_pkg, deoc_checker.
`timescale 1ns / 100ps

module dual_encoder_counter_odometry_core_tb;
  import deoc_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_addr_i = '0;
  logic [31:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;   // left_a, left_b, right_a, right_b, zero pad
  logic         s_axis_tuser = 1'b0; // req_type
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [223:0] m_axis_tdata;        // deltas, speeds, angles
  int           fail_cnt, pending, snaps;
  int           items_sent = 0;
  logic [3:0]   pins = '0;

  dual_encoder_counter_odometry_core DUT (.*);
  deoc_checker u_chk (.*, .fail_cnt_o(fail_cnt), .pending_o(pending), .snaps_o(snaps));

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("** dual_encoder_counter_odometry_core: FAILED **");
    $finish;
  end

  // Random receiver stalls
  always @(posedge clk_i) begin
    if ($urandom_range(0, 99) < 5) m_axis_tready <= 1'b0;
    else if ($urandom_range(0, 3) == 0) m_axis_tready <= ~m_axis_tready;
    else m_axis_tready <= 1'b1;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Send one item and wait for acceptance
  task automatic send_item(input logic kind, input logic [3:0] p, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'd0, p};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [31:0] val);
    s_axis_tvalid <= 1'b0;
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  // Quadrature steps on both wheels, per-wheel direction; each level held hold ticks
  task automatic spin(input int steps, input bit dir_l, input bit dir_r, input int hold);
    logic [1:0] seq [4];
    logic [1:0] l, r;
    int il = 0, ir = 0;
    seq = '{2'b00, 2'b01, 2'b11, 2'b10};
    for (int s = 0; s < steps; s++) begin
      il = dir_l ? (il + 1) % 4 : (il + 3) % 4;
      ir = dir_r ? (ir + 1) % 4 : (ir + 3) % 4;
      l = seq[il]; r = seq[ir];
      for (int h = 0; h < hold; h++) begin
        // occasional single-sample glitch
        if ($urandom_range(0, 19) == 0) send_item(REQ_SAMPLE, 4'($urandom), 1'b1);
        else send_item(REQ_SAMPLE, {r, l}, 1'b1);
      end
    end
  endtask

  initial begin
    int flen;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: defaults, zero period gives zero speed
    cfg_write(CFG_FILTER_LEN, 32'd2);
    send_item(REQ_SNAP, 4'hF, 1'b0);
    spin(6, 1, 0, 2);
    send_item(REQ_SNAP, 4'h0, 1'b0);
    drain();
    // Zero filter length, zero count limit, max rate and period
    cfg_write(CFG_FILTER_LEN, 32'd0);
    cfg_write(CFG_COUNT_LIMIT, 32'd0);
    cfg_write(CFG_PERIOD_MS, 32'd65535);
    cfg_write(CFG_RAD_PER_COUNT, 32'hFFFF_FFFF);
    spin(4, 0, 1, 1);
    send_item(REQ_SNAP, 4'h0, 1'b0);
    drain();
    // Tiny limit, period 1 with max rate: speeds saturate
    cfg_write(CFG_COUNT_LIMIT, 32'd3);
    cfg_write(CFG_PERIOD_MS, 32'd1);
    spin(2, 1, 0, 1);
    send_item(REQ_SNAP, 4'h0, 1'b0);
    spin(2, 0, 1, 1);
    send_item(REQ_SNAP, 4'h0, 1'b0);
    drain();
    // Largest limit and filter length briefly
    cfg_write(CFG_COUNT_LIMIT, 32'd32767);
    cfg_write(CFG_FILTER_LEN, 32'd1023);
    spin(1, 1, 1, 3);
    send_item(REQ_SNAP, 4'h0, 1'b0);
    drain();

    // Random phases
    for (int ph = 0; ph < 12; ph++) begin
      flen = (ph % 3 == 0) ? 0 : $urandom_range(1, 4);
      cfg_write(CFG_FILTER_LEN, flen);
      cfg_write(CFG_COUNT_LIMIT, (ph % 4 == 0) ? $urandom_range(1, 6) : $urandom_range(1, 32767));
      cfg_write(CFG_RAD_PER_COUNT, (ph == 3) ? 32'h0 : $urandom);
      cfg_write(CFG_PERIOD_MS, (ph == 5) ? 32'd0 : $urandom_range(1, 65535));
      for (int k = 0; k < 12; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          for (int n = 0; n < 3; n++) send_item(REQ_SAMPLE, 4'($urandom), 1'b1);
        end else begin
          spin($urandom_range(1, 6), $urandom_range(0, 1), $urandom_range(0, 1), flen + 1);
        end
        send_item(REQ_SNAP, 4'($urandom), 1'b1);
      end
      drain();
    end

    $display("Run covered %0d items and %0d snapshot results over directed and random phases.",
             items_sent, snaps);
    if (fail_cnt == 0) $display("** dual_encoder_counter_odometry_core: PASSED **");
    else $display("** dual_encoder_counter_odometry_core: FAILED **");
    $finish;
  end

endmodule
